### rtl/core/sdspi_pkg.sv
// Shared types and constants for the SD card SPI-mode command sequencer.
// No dependencies; the interfaces, the step logic, the top level and the checker use it.
package sdspi_pkg;

   // item modes
   typedef enum logic [1:0] {
      MODE_CMD   = 2'd0,
      MODE_READ  = 2'd1,
      MODE_BYTE  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   // sequencer phases, one-hot
   typedef enum logic [11:0] {
      PH_IDLE     = 12'b0000_0000_0001,
      PH_HDR      = 12'b0000_0000_0010,
      PH_RESP     = 12'b0000_0000_0100,
      PH_SKIP     = 12'b0000_0000_1000,
      PH_REGTOK   = 12'b0000_0001_0000,
      PH_REGDATA  = 12'b0000_0010_0000,
      PH_OCR      = 12'b0000_0100_0000,
      PH_DUMMY    = 12'b0000_1000_0000,
      PH_SECTOK   = 12'b0001_0000_0000,
      PH_SECDATA  = 12'b0010_0000_0000,
      PH_SECCRC   = 12'b0100_0000_0000,
      PH_ENDDUMMY = 12'b1000_0000_0000
   } phase_type;

   // command numbers with special handling
   localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
   localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
   localparam logic [5:0] CMD_SEND_CID     = 6'd10;
   localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
   localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
   localparam logic [5:0] CMD_READ_OCR     = 6'd58;

   localparam logic [7:0] CRC_CMD8   = 8'h87;
   localparam logic [7:0] CRC_OTHER  = 8'h95;
   localparam logic [1:0] START_BITS = 2'b01;   // top of first header byte (0x40)
   localparam logic [7:0] DATA_TOKEN = 8'hFE;
   localparam logic [7:0] IDLE_BYTE  = 8'hFF;
   localparam int         BUSY_BIT   = 7;       // 0x80: response not yet present
   localparam int         HCS_BIT    = 6;       // OCR card capacity bit

   localparam logic [3:0] HDR_LAST   = 4'd5;    // header bytes after the first
   localparam logic [3:0] IFCOND_TAIL = 4'd4;
   localparam logic [3:0] OCR_TAIL   = 4'd3;
   localparam logic [3:0] CRC_TAIL   = 4'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  cmd_index;
      logic [31:0] cmd_arg;
      logic [8:0]  read_offset;
      logic [9:0]  read_length;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        select_card;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic        done_res;
      logic [7:0]  response;
      logic        read_failed;
      logic        high_capacity;
   } rsp_type;

   // fixed-width part of the sequencer context
   typedef struct packed {
      phase_type   phase;
      logic [5:0]  cmd_latch;
      logic [31:0] arg_latch;
      logic [8:0]  skip_left;
      logic [9:0]  deliver_left;
      logic [7:0]  last_response;
      logic        card_high_capacity;
      logic        sector_mode;
   } ctx_type;

endpackage

### rtl/core/sdspi_ifs.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on sdspi_pkg for the payload structs.
interface sdspi_req_if;
   logic              valid;
   logic              ready;
   sdspi_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sdspi_rsp_if;
   logic              valid;
   logic              ready;
   sdspi_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sd_spi_command_sequencer.sv
// Top level of the SD card SPI-mode command sequencer (host side).
// Depends on sdspi_pkg, sdspi_ifs (channel interfaces) and sdspi_step.
//
// Usage:
//  req_chan carries one item per handshake: start a command (mode 0), start a
//  single-sector read (mode 1), hand over the byte received during the last
//  transfer (mode 2), or clear the card capacity flag (mode 3).
//  rsp_chan returns exactly one item per request: the next byte to shift out
//  with its chip-select level, any register/sector payload byte, and on the
//  last item of an exchange the done flag, response byte and read status.
//  The result of an item is registered and shown on rsp_chan after the
//  accepting edge. Throughput is one item per cycle unless rsp_chan stalls;
//  the only path is step logic from the request port to the result register.
//  When the receiver stalls, the result register holds and req_chan.ready
//  drops; it stays high while the result register is empty or being drained.
//  Synchronous reset empties the result register and puts the sequencer idle
//  with the capacity flag clear.
module sd_spi_command_sequencer #(
   parameter int SECTOR_BYTES   = 512,
   parameter int REGISTER_BYTES = 16,
   parameter int RESPONSE_TRIES = 256,
   parameter int TOKEN_TRIES    = 65536
) (
   input  logic        clock,
   input  logic        reset,
   sdspi_req_if.sink   req_chan,
   sdspi_rsp_if.source rsp_chan
);
   import sdspi_pkg::*;

   localparam int CountMax   = (TOKEN_TRIES - 1 > SECTOR_BYTES) ? TOKEN_TRIES - 1 : SECTOR_BYTES;
   localparam int CountWidth = $clog2(CountMax + 1);
   localparam int PollWidth  = $clog2(RESPONSE_TRIES);

   // sequencer context
   ctx_type               ctx_ff, ctx_in;
   logic [PollWidth-1:0]  poll_ff, poll_in;    // shared response/register-token poll
   logic [CountWidth-1:0] count_ff, count_in;  // header, skip, data and token counter

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic accept;

   // take a new item whenever the result slot is free or being emptied
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   sdspi_step #(
      .SECTOR_BYTES   (SECTOR_BYTES),
      .REGISTER_BYTES (REGISTER_BYTES),
      .RESPONSE_TRIES (RESPONSE_TRIES),
      .TOKEN_TRIES    (TOKEN_TRIES)
   ) u_step (
      .req      (req_chan.data),
      .ctx      (ctx_ff),
      .poll     (poll_ff),
      .count    (count_ff),
      .ctx_in   (ctx_in),
      .poll_in  (poll_in),
      .count_in (count_in),
      .rsp      (rsp_data_in)
   );

   // context advances only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.phase              <= PH_IDLE;
         ctx_ff.cmd_latch          <= '0;
         ctx_ff.arg_latch          <= '0;
         ctx_ff.skip_left          <= '0;
         ctx_ff.deliver_left       <= '0;
         ctx_ff.last_response      <= '0;
         ctx_ff.card_high_capacity <= 1'b0;
         ctx_ff.sector_mode        <= 1'b0;
         poll_ff                   <= '0;
         count_ff                  <= '0;
      end else if (accept) begin
         ctx_ff   <= ctx_in;
         poll_ff  <= poll_in;
         count_ff <= count_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

### rtl/core/sdspi_step.sv
// Next-state and result logic for one item of the SD SPI command sequencer.
// Purely combinational; depends on sdspi_pkg.
module sdspi_step #(
   parameter int SECTOR_BYTES   = 512,
   parameter int REGISTER_BYTES = 16,
   parameter int RESPONSE_TRIES = 256,
   parameter int TOKEN_TRIES    = 65536,
   localparam int CountMax   = (TOKEN_TRIES - 1 > SECTOR_BYTES) ? TOKEN_TRIES - 1 : SECTOR_BYTES,
   localparam int CountWidth = $clog2(CountMax + 1),
   localparam int PollWidth  = $clog2(RESPONSE_TRIES)
) (
   input  sdspi_pkg::req_type     req,
   input  sdspi_pkg::ctx_type     ctx,
   input  logic [PollWidth-1:0]   poll,
   input  logic [CountWidth-1:0]  count,
   output sdspi_pkg::ctx_type     ctx_in,
   output logic [PollWidth-1:0]   poll_in,
   output logic [CountWidth-1:0]  count_in,
   output sdspi_pkg::rsp_type     rsp
);
   import sdspi_pkg::*;

   localparam logic [PollWidth-1:0]  PollLast  = PollWidth'(RESPONSE_TRIES - 1);
   localparam logic [CountWidth-1:0] TokenLast = CountWidth'(TOKEN_TRIES - 1);
   localparam logic [CountWidth-1:0] SectorCnt = CountWidth'(SECTOR_BYTES);
   localparam logic [CountWidth-1:0] RegCnt    = CountWidth'(REGISTER_BYTES);

   logic [5:0]            st_cmd;
   logic [31:0]           st_arg;
   logic                  poll_wrap;
   logic [CountWidth-1:0] count_dec;
   logic [CountWidth-1:0] hdr_k;

   assign poll_wrap = (poll == PollLast);
   assign count_dec = (count != '0) ? count - 1'b1 : '0;
   assign hdr_k     = count + 1'b1;

   // command number and argument for a start item
   always_comb begin
      st_cmd = (req.mode == MODE_READ) ? CMD_READ_SINGLE : req.cmd_index;
      st_arg = req.cmd_arg;
      if (st_cmd inside {CMD_SEND_CSD, CMD_SEND_CID}) begin
         st_arg = '0;
      end
      if (!ctx.card_high_capacity && (st_cmd inside {CMD_READ_SINGLE, CMD_WRITE_SINGLE})) begin
         st_arg = {st_arg[22:0], 9'b0};
      end
   end

   always_comb begin
      ctx_in   = ctx;
      poll_in  = poll;
      count_in = count;
      rsp      = '0;
      rsp.tx_byte = IDLE_BYTE;

      unique case (req.mode)
         MODE_CMD, MODE_READ: begin
            if (req.mode == MODE_READ) begin
               ctx_in.skip_left    = req.read_offset;
               ctx_in.deliver_left = req.read_length;
            end
            ctx_in.cmd_latch     = st_cmd;
            ctx_in.arg_latch     = st_arg;
            ctx_in.sector_mode   = (req.mode == MODE_READ);
            ctx_in.last_response = '0;
            ctx_in.phase         = PH_HDR;
            poll_in  = '0;
            count_in = '0;
            rsp.tx_valid    = 1'b1;
            rsp.tx_byte     = {START_BITS, st_cmd};
            rsp.select_card = 1'b1;
         end
         MODE_BYTE: begin
            unique case (ctx.phase)
               PH_HDR: begin
                  rsp.tx_valid    = 1'b1;
                  rsp.select_card = 1'b1;
                  if (count < CountWidth'(HDR_LAST)) begin
                     count_in = hdr_k;
                     case (hdr_k[2:0])
                        3'd1:    rsp.tx_byte = ctx.arg_latch[31:24];
                        3'd2:    rsp.tx_byte = ctx.arg_latch[23:16];
                        3'd3:    rsp.tx_byte = ctx.arg_latch[15:8];
                        3'd4:    rsp.tx_byte = ctx.arg_latch[7:0];
                        default: rsp.tx_byte = (ctx.cmd_latch == CMD_SEND_IF_COND) ?
                                               CRC_CMD8 : CRC_OTHER;
                     endcase
                  end else begin
                     ctx_in.phase = PH_RESP;
                  end
               end
               PH_RESP: begin
                  if (req.rx_byte[BUSY_BIT]) begin
                     poll_in = poll_wrap ? '0 : poll + 1'b1;
                  end
                  if (!req.rx_byte[BUSY_BIT] || poll_wrap) begin
                     ctx_in.last_response = req.rx_byte;
                     rsp.tx_valid = 1'b1;
                     if (ctx.cmd_latch == CMD_SEND_IF_COND) begin
                        ctx_in.phase    = PH_SKIP;
                        count_in        = CountWidth'(IFCOND_TAIL);
                        rsp.select_card = 1'b1;
                     end else if (ctx.cmd_latch inside {CMD_SEND_CSD, CMD_SEND_CID}) begin
                        ctx_in.phase    = PH_REGTOK;
                        rsp.select_card = 1'b1;
                     end else if (ctx.cmd_latch == CMD_READ_OCR && req.rx_byte == 8'h00) begin
                        ctx_in.phase    = PH_OCR;
                        rsp.select_card = 1'b1;
                     end else begin
                        ctx_in.phase = PH_DUMMY;
                     end
                  end else begin
                     rsp.tx_valid    = 1'b1;
                     rsp.select_card = 1'b1;
                  end
               end
               PH_SKIP: begin
                  count_in     = count_dec;
                  rsp.tx_valid = 1'b1;
                  if (count_dec != '0) begin
                     rsp.select_card = 1'b1;
                  end else begin
                     ctx_in.phase = PH_DUMMY;
                  end
               end
               PH_REGTOK: begin
                  rsp.tx_valid    = 1'b1;
                  rsp.select_card = 1'b1;
                  if (req.rx_byte == DATA_TOKEN) begin
                     ctx_in.phase = PH_REGDATA;
                     count_in     = RegCnt;
                  end else begin
                     poll_in = poll_wrap ? '0 : poll + 1'b1;
                     if (poll_wrap) begin
                        ctx_in.last_response = req.rx_byte;
                        ctx_in.phase         = PH_DUMMY;
                        rsp.select_card      = 1'b0;
                     end
                  end
               end
               PH_REGDATA: begin
                  rsp.data_valid  = 1'b1;
                  rsp.data_byte   = req.rx_byte;
                  rsp.tx_valid    = 1'b1;
                  rsp.select_card = 1'b1;
                  count_in        = count_dec;
                  if (count_dec == '0) begin
                     ctx_in.last_response = '0;
                     ctx_in.phase         = PH_SKIP;
                     count_in             = CountWidth'(CRC_TAIL);
                  end
               end
               PH_OCR: begin
                  ctx_in.card_high_capacity = req.rx_byte[HCS_BIT];
                  ctx_in.phase    = PH_SKIP;
                  count_in        = CountWidth'(OCR_TAIL);
                  rsp.tx_valid    = 1'b1;
                  rsp.select_card = 1'b1;
               end
               PH_DUMMY: begin
                  if (ctx.sector_mode && ctx.last_response == 8'h00) begin
                     ctx_in.phase    = PH_SECTOK;
                     count_in        = '0;
                     rsp.tx_valid    = 1'b1;
                     rsp.select_card = 1'b1;
                  end else begin
                     ctx_in.phase    = PH_IDLE;
                     rsp.done_res    = 1'b1;
                     rsp.response    = ctx.last_response;
                     rsp.read_failed = ctx.sector_mode;
                  end
               end
               PH_SECTOK: begin
                  if (req.rx_byte == DATA_TOKEN) begin
                     ctx_in.phase    = PH_SECDATA;
                     count_in        = SectorCnt;
                     rsp.tx_valid    = 1'b1;
                     rsp.select_card = 1'b1;
                  end else if (count == TokenLast) begin
                     ctx_in.phase    = PH_IDLE;
                     rsp.done_res    = 1'b1;
                     rsp.response    = ctx.last_response;
                     rsp.read_failed = 1'b1;
                  end else begin
                     count_in        = hdr_k;
                     rsp.tx_valid    = 1'b1;
                     rsp.select_card = 1'b1;
                  end
               end
               PH_SECDATA: begin
                  if (ctx.skip_left != '0) begin
                     ctx_in.skip_left = ctx.skip_left - 1'b1;
                  end else if (ctx.deliver_left != '0) begin
                     ctx_in.deliver_left = ctx.deliver_left - 1'b1;
                     rsp.data_valid      = 1'b1;
                     rsp.data_byte       = req.rx_byte;
                  end
                  rsp.tx_valid    = 1'b1;
                  rsp.select_card = 1'b1;
                  count_in        = count_dec;
                  if (count_dec == '0) begin
                     ctx_in.phase = PH_SECCRC;
                     count_in     = CountWidth'(CRC_TAIL);
                  end
               end
               PH_SECCRC: begin
                  count_in     = count_dec;
                  rsp.tx_valid = 1'b1;
                  if (count_dec != '0) begin
                     rsp.select_card = 1'b1;
                  end else begin
                     ctx_in.phase = PH_ENDDUMMY;
                  end
               end
               PH_ENDDUMMY: begin
                  ctx_in.phase = PH_IDLE;
                  rsp.done_res = 1'b1;
                  rsp.response = ctx.last_response;
               end
               default: begin
                  ctx_in.phase = PH_IDLE;
               end
            endcase
         end
         default: begin
            ctx_in.card_high_capacity = 1'b0;
         end
      endcase

      rsp.high_capacity = ctx_in.card_high_capacity;
   end

endmodule

### rtl/core/sdspi_checker.sv
// Port-level assertions for sd_spi_command_sequencer, attached by bind.
// Depends on sdspi_pkg and the channel interfaces of the top level.
module sdspi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input sdspi_pkg::rsp_type rsp_data
);
   import sdspi_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // empty result slot never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty result slot");

   // a delivered payload byte always comes with a further selected transfer
   a_data_needs_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.data_valid |-> rsp_data.tx_valid && rsp_data.select_card)
      else $error("payload byte without next transfer");

   // completion ends the exchange: no transfer, card deselected
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |->
         !rsp_data.tx_valid && !rsp_data.select_card && !rsp_data.data_valid
         && rsp_data.tx_byte == IDLE_BYTE)
      else $error("done item requests a transfer");

   // status fields stay clear until completion
   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.response == 8'h00 && !rsp_data.read_failed)
      else $error("status shown before completion");

endmodule

bind sd_spi_command_sequencer sdspi_checker u_sdspi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

### test/sd_spi_command_sequencer_tb.sv
// Testbench for sd_spi_command_sequencer: directed rows, directed card exchanges, then random ones.
// Each result item is checked against an in-bench model or a result typed in by hand.
// Depends on sdspi_pkg, sdspi_ifs and the sequencer RTL.
module sd_spi_command_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdspi_pkg::*;

   localparam int CLOCK_PERIOD   = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int SECTOR_BYTES   = 512;
   localparam int REGISTER_BYTES = 16;
   localparam int RESPONSE_TRIES = 256;
   localparam int TOKEN_TRIES    = 65536;

   localparam int GAP_PCT        = 23;       // idle cycles per hundred, each side
   localparam int HOLD_START     = 1500;     // receiver hold-off window, in cycles after reset
   localparam int HOLD_CYCLES    = 400;
   localparam int STEADY_START   = 3000;     // receiver never idles in this window
   localparam int STEADY_END     = 20000;
   localparam int RANDOM_ITEMS   = 400;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 1500000;

   logic clock;
   logic reset;

   sdspi_req_if req_chan ();
   sdspi_rsp_if rsp_chan ();

   sd_spi_command_sequencer #(
      .SECTOR_BYTES   (SECTOR_BYTES),
      .REGISTER_BYTES (REGISTER_BYTES),
      .RESPONSE_TRIES (RESPONSE_TRIES),
      .TOKEN_TRIES    (TOKEN_TRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // directed row: the item plus, where obvious, the result typed in by hand
   typedef struct packed {
      req_type item;
      logic    typed_ok;
      rsp_type typed;
   } step_row_type;

   step_row_type directed_rows[$];
   rsp_type due_results[$];      // results owed by the block, oldest first
   int      errors;
   int      live_items;          // items the block acts on (stray bytes while idle excluded)
   int      gap_pct;

   // ---------------------------------------------------------------
   // Sequencer model state
   // ---------------------------------------------------------------
   phase_type   ph;
   logic [5:0]  cur_cmd;
   logic [31:0] cur_arg;
   int          poll_n;          // shared by response poll and register token wait
   int          byte_n;
   logic [8:0]  skip_n;
   logic [9:0]  deliver_n;
   logic [7:0]  last_resp;
   logic        hc;              // card is block addressed
   logic        sector_op;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic rsp_type idle_rsp();
      rsp_type o;
      o = '0;
      o.tx_byte = IDLE_BYTE;
      return o;
   endfunction

   function automatic rsp_type xfer_rsp(logic [7:0] b, logic sel);
      rsp_type o;
      o = idle_rsp();
      o.tx_valid = 1'b1;
      o.tx_byte = b;
      o.select_card = sel;
      return o;
   endfunction

   function automatic rsp_type done_rsp(logic [7:0] resp, logic failed);
      rsp_type o;
      o = idle_rsp();
      o.done_res = 1'b1;
      o.response = resp;
      o.read_failed = failed;
      return o;
   endfunction

   function automatic void put_tx(inout rsp_type o, input logic [7:0] b, input logic sel);
      o.tx_valid = 1'b1;
      o.tx_byte = b;
      o.select_card = sel;
   endfunction

   // deselect and clock the trailing dummy byte
   function automatic void end_command(inout rsp_type o);
      ph = PH_DUMMY;
      put_tx(o, IDLE_BYTE, 1'b0);
   endfunction

   function automatic void finish_exchange(inout rsp_type o, input logic failed);
      o.done_res = 1'b1;
      o.response = last_resp;
      o.read_failed = failed;
      ph = PH_IDLE;
   endfunction

   // true when the shared poll counter wraps
   function automatic logic poll_expired();
      poll_n++;
      if (poll_n >= RESPONSE_TRIES) begin
         poll_n = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] hdr_byte(int k);
      if (k == 0) return {START_BITS, cur_cmd};
      if (k >= HDR_LAST) return (cur_cmd == CMD_SEND_IF_COND) ? CRC_CMD8 : CRC_OTHER;
      return cur_arg[8 * (4 - k) +: 8];
   endfunction

   // Advance the model by one accepted item and return the result it owes.
   function automatic rsp_type sequencer_step(req_type r);
      rsp_type     o;
      logic [5:0]  c;
      logic [31:0] a;
      logic [7:0]  rx;
      logic        got;
      o = idle_rsp();
      rx = r.rx_byte;
      if (r.mode == MODE_CMD || r.mode == MODE_READ) begin
         // any start abandons whatever is running
         if (r.mode == MODE_READ) begin
            skip_n = r.read_offset;
            deliver_n = r.read_length;
            c = CMD_READ_SINGLE;
         end else begin
            c = r.cmd_index;
         end
         a = r.cmd_arg;
         if (c == CMD_SEND_CSD || c == CMD_SEND_CID) a = '0;
         if (!hc && (c == CMD_READ_SINGLE || c == CMD_WRITE_SINGLE)) a = a << 9;
         cur_cmd = c;
         cur_arg = a;
         sector_op = (r.mode == MODE_READ);
         last_resp = '0;
         poll_n = 0;
         byte_n = 0;
         ph = PH_HDR;
         put_tx(o, hdr_byte(0), 1'b1);
      end else if (r.mode == MODE_CLEAR) begin
         hc = 1'b0;
      end else begin
         case (ph)
            PH_HDR: begin
               if (byte_n < HDR_LAST) begin
                  byte_n++;
                  put_tx(o, hdr_byte(byte_n), 1'b1);
               end else begin
                  ph = PH_RESP;
                  put_tx(o, IDLE_BYTE, 1'b1);
               end
            end
            PH_RESP: begin
               if (!rx[BUSY_BIT]) got = 1'b1;
               else got = poll_expired();
               if (got) begin
                  last_resp = rx;
                  if (cur_cmd == CMD_SEND_IF_COND) begin
                     ph = PH_SKIP;
                     byte_n = IFCOND_TAIL;
                     put_tx(o, IDLE_BYTE, 1'b1);
                  end else if (cur_cmd == CMD_SEND_CSD || cur_cmd == CMD_SEND_CID) begin
                     ph = PH_REGTOK;
                     put_tx(o, IDLE_BYTE, 1'b1);
                  end else if (cur_cmd == CMD_READ_OCR && last_resp == 8'h00) begin
                     ph = PH_OCR;
                     put_tx(o, IDLE_BYTE, 1'b1);
                  end else begin
                     end_command(o);
                  end
               end else begin
                  put_tx(o, IDLE_BYTE, 1'b1);
               end
            end
            PH_SKIP: begin
               if (byte_n > 0) byte_n--;
               if (byte_n > 0) put_tx(o, IDLE_BYTE, 1'b1);
               else end_command(o);
            end
            PH_REGTOK: begin
               if (rx == DATA_TOKEN) begin
                  ph = PH_REGDATA;
                  byte_n = REGISTER_BYTES;
                  put_tx(o, IDLE_BYTE, 1'b1);
               end else if (poll_expired()) begin
                  last_resp = rx;
                  end_command(o);
               end else begin
                  put_tx(o, IDLE_BYTE, 1'b1);
               end
            end
            PH_REGDATA: begin
               o.data_valid = 1'b1;
               o.data_byte = rx;
               if (byte_n > 0) byte_n--;
               if (byte_n > 0) begin
                  put_tx(o, IDLE_BYTE, 1'b1);
               end else begin
                  last_resp = '0;
                  ph = PH_SKIP;
                  byte_n = CRC_TAIL;
                  put_tx(o, IDLE_BYTE, 1'b1);
               end
            end
            PH_OCR: begin
               hc = rx[HCS_BIT];
               ph = PH_SKIP;
               byte_n = OCR_TAIL;
               put_tx(o, IDLE_BYTE, 1'b1);
            end
            PH_DUMMY: begin
               if (!sector_op) begin
                  finish_exchange(o, 1'b0);
               end else if (last_resp != 8'h00) begin
                  finish_exchange(o, 1'b1);     // card rejected the read
               end else begin
                  ph = PH_SECTOK;
                  byte_n = 0;
                  put_tx(o, IDLE_BYTE, 1'b1);
               end
            end
            PH_SECTOK: begin
               if (rx == DATA_TOKEN) begin
                  ph = PH_SECDATA;
                  byte_n = SECTOR_BYTES;
                  put_tx(o, IDLE_BYTE, 1'b1);
               end else begin
                  byte_n++;
                  if (byte_n >= TOKEN_TRIES) finish_exchange(o, 1'b1);
                  else put_tx(o, IDLE_BYTE, 1'b1);
               end
            end
            PH_SECDATA: begin
               // offset bytes are dropped first, then the delivery window
               if (skip_n > 0) begin
                  skip_n--;
               end else if (deliver_n > 0) begin
                  deliver_n--;
                  o.data_valid = 1'b1;
                  o.data_byte = rx;
               end
               if (byte_n > 0) byte_n--;
               if (byte_n > 0) begin
                  put_tx(o, IDLE_BYTE, 1'b1);
               end else begin
                  ph = PH_SECCRC;
                  byte_n = CRC_TAIL;
                  put_tx(o, IDLE_BYTE, 1'b1);
               end
            end
            PH_SECCRC: begin
               if (byte_n > 0) byte_n--;
               if (byte_n > 0) begin
                  put_tx(o, IDLE_BYTE, 1'b1);
               end else begin
                  ph = PH_ENDDUMMY;
                  put_tx(o, IDLE_BYTE, 1'b0);
               end
            end
            PH_ENDDUMMY: finish_exchange(o, 1'b0);
            default: ph = PH_IDLE;          // byte while idle: nothing happens
         endcase
      end
      o.high_capacity = hc;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Item construction
   // ---------------------------------------------------------------
   function automatic req_type rand_req();
      req_type r;
      r.mode        = 2'($urandom_range(3));
      r.cmd_index   = 6'($urandom_range(63));
      r.cmd_arg     = $urandom;
      r.read_offset = 9'($urandom_range(511));
      r.read_length = 10'($urandom_range(1023));
      r.rx_byte     = 8'($urandom_range(255));
      return r;
   endfunction

   function automatic req_type mk_req(mode_type m, logic [5:0] c, logic [31:0] a,
                                      logic [8:0] off, logic [9:0] len, logic [7:0] rx);
      req_type r;
      r.mode = m;
      r.cmd_index = c;
      r.cmd_arg = a;
      r.read_offset = off;
      r.read_length = len;
      r.rx_byte = rx;
      return r;
   endfunction

   function automatic req_type cmd_req(logic [5:0] c, logic [31:0] a);
      req_type r;
      r = rand_req();
      r.mode = MODE_CMD;
      r.cmd_index = c;
      r.cmd_arg = a;
      return r;
   endfunction

   function automatic req_type read_req(logic [31:0] a, logic [8:0] off, logic [9:0] len);
      req_type r;
      r = rand_req();
      r.mode = MODE_READ;
      r.cmd_arg = a;
      r.read_offset = off;
      r.read_length = len;
      return r;
   endfunction

   function automatic void add_row(req_type item, logic typed_ok, rsp_type typed);
      step_row_type s;
      s.item = item;
      s.typed_ok = typed_ok;
      s.typed = typed;
      directed_rows.push_back(s);
   endfunction

   // ---------------------------------------------------------------
   // Sender: offer one item, wait for the handshake, book its result.
   // Called and returning at a rising edge.
   // ---------------------------------------------------------------
   task automatic push(input req_type r, input logic typed_ok = 1'b0,
                       input rsp_type typed = '0);
      rsp_type pred;
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (!(r.mode == MODE_BYTE && ph == PH_IDLE)) live_items++;
      pred = sequencer_step(r);
      due_results.push_back(typed_ok ? typed : pred);
   endtask

   // stop offering and wait for every owed result
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   // Play the card side of one exchange. The card's reply bytes follow the
   // model's phase: busy bytes then the response, optional token waits.
   // noise_pm: per-mille chance per byte of a capacity clear or an abandon.
   task automatic run_exchange(input req_type first, input int busy_n,
                               input logic [7:0] reply, input int tok_wait,
                               input logic [7:0] ocr_byte, input int noise_pm);
      req_type    r;
      logic [7:0] rx;
      push(first);
      while (ph != PH_IDLE) begin
         if ($urandom_range(999) < noise_pm) begin
            if ($urandom_range(1) == 0) break;     // next start cuts in
            r = rand_req();
            r.mode = MODE_CLEAR;
            push(r);
         end
         rx = 8'($urandom_range(255));
         case (ph)
            PH_RESP: begin
               if (busy_n > 0) begin
                  busy_n--;
                  rx[BUSY_BIT] = 1'b1;
               end else begin
                  rx = reply;
               end
            end
            PH_REGTOK, PH_SECTOK: begin
               if (tok_wait > 0) begin
                  tok_wait--;
                  if (rx == DATA_TOKEN) rx = IDLE_BYTE;
               end else begin
                  rx = DATA_TOKEN;
               end
            end
            PH_OCR: rx = ocr_byte;
            default: ;
         endcase
         r = rand_req();
         r.mode = MODE_BYTE;
         r.rx_byte = rx;
         push(r);
      end
   endtask

   // ---------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------
   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result, expected none, got %h", $time, got);
         end else begin
            want = due_results.pop_front();
            check_field("tx_valid",      want.tx_valid,      got.tx_valid);
            check_field("tx_byte",       want.tx_byte,       got.tx_byte);
            check_field("select_card",   want.select_card,   got.select_card);
            check_field("data_valid",    want.data_valid,    got.data_valid);
            check_field("data_byte",     want.data_byte,     got.data_byte);
            check_field("done_res",      want.done_res,      got.done_res);
            check_field("response",      want.response,      got.response);
            check_field("read_failed",   want.read_failed,   got.read_failed);
            check_field("high_capacity", want.high_capacity, got.high_capacity);
         end
      end
   end

   // Receiver: random stalls, one long hold-off so the result register
   // backs up into the request port, and a long window with no stalls.
   initial begin
      int n;
      n = 0;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n++;
         if (n >= HOLD_START && n < HOLD_START + HOLD_CYCLES)
            rsp_chan.ready <= 1'b0;
         else if (n >= STEADY_START && n < STEADY_END)
            rsp_chan.ready <= 1'b1;
         else
            rsp_chan.ready <= ($urandom_range(99) >= GAP_PCT);
         @(posedge clock);
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------
   // Main stimulus
   // ---------------------------------------------------------------
   initial begin
      req_type    r;
      int         live_goal;
      logic       paused;
      int         busy_n;
      logic [7:0] reply;
      int         tok_wait;
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      errors = 0;
      live_items = 0;
      gap_pct = GAP_PCT;
      paused = 1'b0;

      // model after reset
      ph = PH_IDLE;
      cur_cmd = '0;
      cur_arg = '0;
      poll_n = 0;
      byte_n = 0;
      skip_n = '0;
      deliver_n = '0;
      last_resp = '0;
      hc = 1'b0;
      sector_op = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed rows ---
      // idle: stray byte and clear just echo the idle result
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b1, idle_rsp());
      add_row(mk_req(MODE_BYTE, 6'd63, 32'hFFFF_FFFF, 9'd511, 10'd1023, 8'hFF),
              1'b1, idle_rsp());
      add_row(mk_req(MODE_CLEAR, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b1, idle_rsp());
      // CMD0 start, then abandoned by a CMD63 start with an all-ones argument
      add_row(mk_req(MODE_CMD, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b1,
              xfer_rsp(8'h40, 1'b1));
      add_row(mk_req(MODE_CMD, 6'd63, 32'hFFFF_FFFF, 9'd0, 10'd0, 8'hFF), 1'b1,
              xfer_rsp(8'h7F, 1'b1));
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b1,
              xfer_rsp(8'hFF, 1'b1));
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'hFF), 1'b1,
              xfer_rsp(8'hFF, 1'b1));
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b1,
              xfer_rsp(8'hFF, 1'b1));
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'hFF), 1'b1,
              xfer_rsp(8'hFF, 1'b1));
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b1,
              xfer_rsp(CRC_OTHER, 1'b1));
      // response poll: one busy byte, then 0x7F
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b0, '0);
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h80), 1'b0, '0);
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h7F), 1'b0, '0);
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b1,
              done_rsp(8'h7F, 1'b0));
      // sector read of sector 1, cleared mid-exchange, then rejected with 0x05
      add_row(mk_req(MODE_READ, 6'd0, 32'h1, 9'd0, 10'd512, 8'h00), 1'b1,
              xfer_rsp(8'h51, 1'b1));
      add_row(mk_req(MODE_CLEAR, 6'd0, 32'h0, 9'd0, 10'd0, 8'h00), 1'b1, idle_rsp());
      repeat (6) add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'hFF), 1'b0, '0);
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'h05), 1'b0, '0);
      add_row(mk_req(MODE_BYTE, 6'd0, 32'h0, 9'd0, 10'd0, 8'hFF), 1'b1,
              done_rsp(8'h05, 1'b1));

      foreach (directed_rows[i])
         push(directed_rows[i].item, directed_rows[i].typed_ok, directed_rows[i].typed);

      // --- directed exchanges ---
      run_exchange(cmd_req(CMD_SEND_IF_COND, 32'h0000_01AA), 2, 8'h01, 0, 8'h00, 0);
      run_exchange(cmd_req(CMD_READ_OCR, 32'h0), 1, 8'h00, 0, 8'hC0, 0);       // sets hc
      run_exchange(cmd_req(CMD_READ_SINGLE, 32'hFFFF_FFFF), 0, 8'h00, 0, 8'h00, 0);
      run_exchange(read_req(32'h1234_5678, 9'd0, 10'd512), 0, 8'h00, 3, 8'h00, 0);
      run_exchange(cmd_req(CMD_READ_OCR, 32'h0), 0, 8'h01, 0, 8'hFF, 0);       // no OCR
      run_exchange(cmd_req(CMD_READ_OCR, 32'h0), 0, 8'h00, 0, 8'hBF, 0);       // clears hc
      run_exchange(cmd_req(CMD_WRITE_SINGLE, 32'hFFFF_FFFF), 3, 8'h00, 0, 8'h00, 0);
      run_exchange(cmd_req(CMD_SEND_CSD, 32'hFFFF_FFFF), 0, 8'h00, 2, 8'h00, 0);
      run_exchange(cmd_req(CMD_SEND_CID, 32'hA5A5_A5A5), 1, 8'h7F, 1, 8'h00, 0);
      run_exchange(cmd_req(CMD_SEND_CID, 32'h0), 0, 8'h04, 300, 8'h00, 0);     // token lost
      run_exchange(cmd_req(6'd0, 32'h0), 300, 8'h00, 0, 8'h00, 0);             // no response
      run_exchange(read_req(32'hFFFF_FFFF, 9'd511, 10'd1023), 0, 8'h00, 0, 8'h00, 0);
      run_exchange(read_req(32'h0, 9'd100, 10'd0), 0, 8'h00, 1, 8'h00, 0);
      // start token never comes; sender runs flat out through the whole wait
      gap_pct = 0;
      run_exchange(read_req(32'h55, 9'd0, 10'd16), 0, 8'h00, TOKEN_TRIES + 10, 8'h00, 0);
      gap_pct = GAP_PCT;

      settle();

      // --- random exchanges ---
      live_goal = live_items + RANDOM_ITEMS;
      while (live_items < live_goal) begin
         // once, midway: hold the sender until the block has drained
         if (!paused && live_items >= live_goal - RANDOM_ITEMS / 2) begin
            settle();
            paused = 1'b1;
         end
         // occasional stray byte or clear between exchanges
         if ($urandom_range(9) == 0) begin
            r = rand_req();
            r.mode = ($urandom_range(1) == 0) ? MODE_BYTE : MODE_CLEAR;
            push(r);
         end
         busy_n   = ($urandom_range(19) == 0) ? RESPONSE_TRIES + 4 : $urandom_range(3);
         reply    = ($urandom_range(9) < 7) ? 8'h00 : 8'($urandom_range(127));
         tok_wait = ($urandom_range(19) == 0) ? 300 : $urandom_range(4);
         if ($urandom_range(99) < 8) begin
            r = rand_req();
            r.mode = MODE_READ;
            case ($urandom_range(3))
               0: begin r.read_offset = 9'd0;   r.read_length = 10'd512;  end
               1: begin r.read_offset = 9'd511; r.read_length = 10'd1023; end
               default: ;
            endcase
            run_exchange(r, busy_n, reply, tok_wait, 8'($urandom_range(255)), 2);
         end else begin
            case ($urandom_range(8))
               0: r = cmd_req(6'd0, $urandom);
               1: r = cmd_req(CMD_SEND_IF_COND, $urandom);
               2: r = cmd_req(CMD_SEND_CSD, $urandom);
               3: r = cmd_req(CMD_SEND_CID, $urandom);
               4: r = cmd_req(CMD_READ_SINGLE, $urandom);
               5: r = cmd_req(CMD_WRITE_SINGLE, $urandom);
               6: r = cmd_req(CMD_READ_OCR, $urandom);
               7: r = cmd_req(6'd63, $urandom);
               default: r = cmd_req(6'($urandom_range(63)), $urandom);
            endcase
            run_exchange(r, busy_n, reply, tok_wait, 8'($urandom_range(255)), 10);
         end
      end

      // --- wind down ---
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
